>>> rtl/core/bfbi_pkg.sv
`default_nettype none

package bfbi_pkg;

  // Default sizes of the buffer and of the widest field.
  localparam int BUFFER_BYTES_DEF   = 256;
  localparam int MAX_FIELD_BITS_DEF = 64;

  // Fixed widths of the interface.
  localparam int SRC_BITS      = 64;
  localparam int BYTE_BITS     = 8;
  localparam int LIMIT_BITS    = 9;
  localparam int OFFSET_BITS   = 11;
  localparam int FWIDTH_BITS   = 7;
  localparam int WINDOW_BITS   = SRC_BITS + BYTE_BITS;
  localparam int BYTE_CNT_BITS = 4;

  // Reset value of the bytes-in-use register before clamping to the store size.
  localparam int BYTES_IN_USE_RST = 256;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_RD_BYTE = 2'd1,
    OP_INSERT  = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_RMW,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/bit_field_buffer_insert_top.sv
// Byte write: busy stays low.
// Byte read: the result beat comes in the cycle after the item is taken.
// Field insert: busy in PREP, RMW and DRAIN, k = 1..9 bytes touched, one read-modify-write
// per cycle through the single write port and registered read port of the byte store.
// Reset clears the control state and sets bytes_in_use to 256 (at most the store size);
// the byte store is not cleared. Result beats cannot be stalled by the receiver.
`default_nettype none

module bit_field_buffer_insert_top
  import bfbi_pkg::*;
#(
  parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             op_i,
  input  wire logic [7:0]             byte_index_i,
  input  wire logic [BYTE_BITS-1:0]   byte_data_i,
  input  wire logic [OFFSET_BITS-1:0] dst_offset_i,
  input  wire logic [FWIDTH_BITS-1:0] dst_width_i,
  input  wire logic [SRC_BITS-1:0]    field_value_i,
  input  wire logic [FWIDTH_BITS-1:0] value_width_i,
  output logic      [BYTE_BITS-1:0]   read_data_o,
  output logic                        read_valid_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  localparam int Aw      = $clog2(BUFFER_BYTES);
  localparam int RstUsed = (BUFFER_BYTES < BYTES_IN_USE_RST) ? BUFFER_BYTES
                                                              : BYTES_IN_USE_RST;

  logic [LIMIT_BITS-1:0] bytes_in_use_q, lim;
  logic                  cfg_wr;
  logic                  mem_we;
  logic [Aw-1:0]         mem_waddr, mem_raddr;
  logic [BYTE_BITS-1:0]  mem_wdata, mem_rdata;

  // Configuration register, word 0 only.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_in_use_q <= LIMIT_BITS'(RstUsed);
    end else if (cfg_wr) begin
      bytes_in_use_q <= pwdata[LIMIT_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {23'b0, bytes_in_use_q} : '0;

  // Bytes actually in use never exceed the store.
  assign lim = (32'(bytes_in_use_q) > BUFFER_BYTES) ? LIMIT_BITS'(BUFFER_BYTES)
                                                    : bytes_in_use_q;

  bfbi_seq #(
    .MaxFieldBits(MAX_FIELD_BITS),
    .Aw          (Aw)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .op_i,
    .byte_index_i,
    .byte_data_i,
    .dst_offset_i,
    .dst_width_i,
    .field_value_i,
    .value_width_i,
    .lim_i      (lim),
    .read_data_o,
    .read_valid_o,
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  bfbi_mem #(
    .Depth(BUFFER_BYTES),
    .Aw   (Aw)
  ) u_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/bfbi_mem.sv
`default_nettype none

module bfbi_mem
  import bfbi_pkg::*;
#(
  parameter int Depth = BUFFER_BYTES_DEF,
  parameter int Aw    = $clog2(BUFFER_BYTES_DEF)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [Aw-1:0]        waddr_i,
  input  wire logic [BYTE_BITS-1:0] wdata_i,
  input  wire logic [Aw-1:0]        raddr_i,
  output logic      [BYTE_BITS-1:0] rdata_o
);

  logic [BYTE_BITS-1:0] mem_q [Depth];
  logic [BYTE_BITS-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bfbi_seq.sv
`default_nettype none

module bfbi_seq
  import bfbi_pkg::*;
#(
  parameter int MaxFieldBits = MAX_FIELD_BITS_DEF,
  parameter int Aw           = $clog2(BUFFER_BYTES_DEF)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             op_i,
  input  wire logic [7:0]             byte_index_i,
  input  wire logic [BYTE_BITS-1:0]   byte_data_i,
  input  wire logic [OFFSET_BITS-1:0] dst_offset_i,
  input  wire logic [FWIDTH_BITS-1:0] dst_width_i,
  input  wire logic [SRC_BITS-1:0]    field_value_i,
  input  wire logic [FWIDTH_BITS-1:0] value_width_i,
  input  wire logic [LIMIT_BITS-1:0]  lim_i,
  output logic      [BYTE_BITS-1:0]   read_data_o,
  output logic                        read_valid_o,
  output logic                        mem_we_o,
  output logic      [Aw-1:0]          mem_waddr_o,
  output logic      [BYTE_BITS-1:0]   mem_wdata_o,
  output logic      [Aw-1:0]          mem_raddr_o,
  input  wire logic [BYTE_BITS-1:0]   mem_rdata_i
);

  state_e state_q, state_d;
  op_e    op;
  logic   accept;
  logic   idx_ok;

  logic [FWIDTH_BITS-1:0] fw_sat, vw_sat, n_len;

  // Registered item and walking window.
  logic                     rd_ok_q;
  logic [OFFSET_BITS-1:0]   off_q;
  logic [FWIDTH_BITS-1:0]   n_q, vw_q;
  logic [SRC_BITS-1:0]      val_q;
  logic [WINDOW_BITS-1:0]   win_q, msk_q, win_d, msk_d;
  logic [BYTE_CNT_BITS-1:0] cnt_q, last_q, last_d;
  logic [SRC_BITS-1:0]      aligned, top_mask;
  logic [LIMIT_BITS-1:0]    cur_idx;

  // Write-back stage of the read-modify-write.
  logic                 stg_vld_q, stg_ok_q;
  logic [Aw-1:0]        stg_addr_q;
  logic [BYTE_BITS-1:0] stg_bits_q, stg_msk_q;

  assign op     = op_e'(op_i);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign idx_ok = ({1'b0, byte_index_i} < lim_i);

  // Saturate both widths; the field length is the smaller one.
  always_comb begin
    fw_sat = (dst_width_i > FWIDTH_BITS'(MaxFieldBits)) ? FWIDTH_BITS'(MaxFieldBits)
                                                        : dst_width_i;
    vw_sat = (value_width_i > FWIDTH_BITS'(SRC_BITS)) ? FWIDTH_BITS'(SRC_BITS)
                                                      : value_width_i;
    n_len  = (fw_sat < vw_sat) ? fw_sat : vw_sat;
  end

  // Left-align the field bits and place them at the bit offset within the first byte.
  always_comb begin
    aligned  = val_q << (FWIDTH_BITS'(SRC_BITS) - vw_q);
    top_mask = ~({SRC_BITS{1'b1}} >> n_q);
    win_d    = {aligned & top_mask, {BYTE_BITS{1'b0}}} >> off_q[2:0];
    msk_d    = {top_mask, {BYTE_BITS{1'b0}}} >> off_q[2:0];
    last_d   = BYTE_CNT_BITS'(({4'b0, off_q[2:0]} + n_q - 7'd1) >> 3);
  end

  assign cur_idx = {1'b0, off_q[OFFSET_BITS-1:3]} + {5'b0, cnt_q};

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      stg_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      stg_vld_q <= (state_q == ST_RMW);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_RD_BYTE: state_d = ST_READ;
            OP_INSERT:  state_d = (n_len != '0) ? ST_PREP : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_PREP:  state_d = ST_RMW;
      ST_RMW:   state_d = (cnt_q == last_q) ? ST_DRAIN : ST_RMW;
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q <= idx_ok;
      off_q   <= dst_offset_i;
      n_q     <= n_len;
      vw_q    <= vw_sat;
      val_q   <= field_value_i;
    end
    if (state_q == ST_PREP) begin
      win_q  <= win_d;
      msk_q  <= msk_d;
      last_q <= last_d;
      cnt_q  <= '0;
    end else if (state_q == ST_RMW) begin
      win_q      <= win_q << BYTE_BITS;
      msk_q      <= msk_q << BYTE_BITS;
      cnt_q      <= cnt_q + 1'b1;
      stg_addr_q <= Aw'(cur_idx);
      stg_bits_q <= win_q[WINDOW_BITS-1 -: BYTE_BITS];
      stg_msk_q  <= msk_q[WINDOW_BITS-1 -: BYTE_BITS];
      stg_ok_q   <= (cur_idx < lim_i);
    end
  end

  // Memory ports: merged write-back during an insert, else a direct byte write.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = Aw'(byte_index_i);
    mem_wdata_o = byte_data_i;
    if (stg_vld_q) begin
      mem_we_o    = stg_ok_q;
      mem_waddr_o = stg_addr_q;
      mem_wdata_o = (mem_rdata_i & ~stg_msk_q) | (stg_bits_q & stg_msk_q);
    end else if (accept && (op == OP_WR_BYTE)) begin
      mem_we_o = idx_ok;
    end
    mem_raddr_o = (state_q == ST_RMW) ? Aw'(cur_idx) : Aw'(byte_index_i);
  end

  // Result beat for a byte read.
  assign read_valid_o = (state_q == ST_READ);
  assign read_data_o  = rd_ok_q ? mem_rdata_i : '0;

  // A result beat lasts exactly one cycle.
  a_beat_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result beat held for more than one cycle");

  // An accepted byte read produces its beat in the next cycle.
  a_read_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_RD_BYTE)) |=> read_valid_o)
    else $error("byte read without a result beat");

  // The byte walk never passes the last touched byte.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> (cnt_q <= last_q))
    else $error("insert walked past its last byte");

  // The write-back stage is only live in the cycle after a walk step.
  a_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q |-> ((state_q == ST_RMW) || (state_q == ST_DRAIN)))
    else $error("write-back stage outside an insert");

endmodule

`default_nettype wire

>>> dv/tb_bit_field_buffer_insert_top.sv
`default_nettype none

module tb_bit_field_buffer_insert_top;
  import bfbi_pkg::*;

  // Op code left unused by the block, and the register map.
  localparam logic [1:0] OP_UNUSED         = 2'd3;
  localparam logic [2:0] BYTES_IN_USE_ADDR = 3'd0;
  localparam int         SETTLE_CYCLES     = 16;
  localparam int         DRAIN_LIMIT       = 4000;
  localparam int         PHASE_ITEMS       = 132;

  typedef struct {
    logic [1:0]             op;
    logic [7:0]             byte_index;
    logic [BYTE_BITS-1:0]   byte_data;
    logic [OFFSET_BITS-1:0] dst_offset;
    logic [FWIDTH_BITS-1:0] dst_width;
    logic [SRC_BITS-1:0]    field_value;
    logic [FWIDTH_BITS-1:0] value_width;
  } buf_cmd_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             op_i;
  logic [7:0]             byte_index_i;
  logic [BYTE_BITS-1:0]   byte_data_i;
  logic [OFFSET_BITS-1:0] dst_offset_i;
  logic [FWIDTH_BITS-1:0] dst_width_i;
  logic [SRC_BITS-1:0]    field_value_i;
  logic [FWIDTH_BITS-1:0] value_width_i;
  logic [BYTE_BITS-1:0]   read_data_o;
  logic                   read_valid_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // Shadow copy of the buffer, with a mask of the bits that have been written.
  logic [7:0] shadow_bytes [BUFFER_BYTES_DEF];
  logic [7:0] bits_written [BUFFER_BYTES_DEF];
  int         shadow_limit;
  logic [7:0] pending_reads [$];
  int         err_count;

  bit_field_buffer_insert_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .byte_index_i  (byte_index_i),
    .byte_data_i   (byte_data_i),
    .dst_offset_i  (dst_offset_i),
    .dst_width_i   (dst_width_i),
    .field_value_i (field_value_i),
    .value_width_i (value_width_i),
    .read_data_o   (read_data_o),
    .read_valid_o  (read_valid_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Bytes that the block actually uses: the register value capped at the store size.
  function automatic int active_bytes();
    return (shadow_limit > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : shadow_limit;
  endfunction

  // Applies one accepted command to the shadow buffer and queues the byte a read returns.
  function automatic void predict_buffer_op(input buf_cmd_t c);
    int lim;
    int fw;
    int vw;
    int n;
    int pos;
    int idx;
    int sel;
    lim = active_bytes();
    case (c.op)
      OP_WR_BYTE: begin
        if (int'(c.byte_index) < lim) begin
          shadow_bytes[c.byte_index] = c.byte_data;
          bits_written[c.byte_index] = 8'hff;
        end
      end
      OP_RD_BYTE: begin
        pending_reads.push_back((int'(c.byte_index) < lim) ? shadow_bytes[c.byte_index] : 8'h00);
      end
      OP_INSERT: begin
        fw = (int'(c.dst_width) > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : int'(c.dst_width);
        vw = (int'(c.value_width) > SRC_BITS) ? SRC_BITS : int'(c.value_width);
        n  = (fw < vw) ? fw : vw;
        // Source bits go out MSB first; bits past the bytes in use are dropped.
        for (int i = 0; i < n; i++) begin
          pos = int'(c.dst_offset) + i;
          idx = pos / 8;
          if (idx < lim) begin
            sel = 7 - (pos % 8);
            shadow_bytes[idx][sel] = c.field_value[vw - 1 - i];
            bits_written[idx][sel] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // A read of an in-range byte must only hit a byte whose bits were all written.
  function automatic buf_cmd_t keep_reads_defined(input buf_cmd_t c);
    int       lim;
    int       known [$];
    buf_cmd_t r;
    r   = c;
    lim = active_bytes();
    if (r.op == OP_RD_BYTE && int'(r.byte_index) < lim && bits_written[r.byte_index] != 8'hff)
    begin
      for (int i = 0; i < lim; i++) begin
        if (bits_written[i] == 8'hff) known.push_back(i);
      end
      if (known.size() > 0) begin
        r.byte_index = 8'(known[$urandom_range(known.size() - 1)]);
      end else if (lim < BUFFER_BYTES_DEF) begin
        r.byte_index = 8'($urandom_range(BUFFER_BYTES_DEF - 1, lim));
      end else begin
        r.op = OP_WR_BYTE;
      end
    end
    return r;
  endfunction

  // Drives one command and holds it until the beat is taken.
  task automatic send_cmd(input buf_cmd_t c);
    buf_cmd_t lc;
    lc = keep_reads_defined(c);
    @(negedge clk_i);
    start          <= 1'b1;
    op_i           <= lc.op;
    byte_index_i   <= lc.byte_index;
    byte_data_i    <= lc.byte_data;
    dst_offset_i   <= lc.dst_offset;
    dst_width_i    <= lc.dst_width;
    field_value_i  <= lc.field_value;
    value_width_i  <= lc.value_width;
    do @(posedge clk_i); while (busy);
    predict_buffer_op(lc);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Fields that the op ignores still get random values.
  function automatic buf_cmd_t noise_cmd(input logic [1:0] op);
    buf_cmd_t c;
    c.op           = op;
    c.byte_index   = 8'($urandom);
    c.byte_data    = 8'($urandom);
    c.dst_offset   = OFFSET_BITS'($urandom);
    c.dst_width    = FWIDTH_BITS'($urandom);
    c.field_value  = {$urandom, $urandom};
    c.value_width  = FWIDTH_BITS'($urandom);
    return c;
  endfunction

  task automatic write_byte(input int idx, input logic [7:0] data);
    buf_cmd_t c;
    c            = noise_cmd(OP_WR_BYTE);
    c.byte_index = 8'(idx);
    c.byte_data  = data;
    send_cmd(c);
  endtask

  task automatic read_byte(input int idx);
    buf_cmd_t c;
    c            = noise_cmd(OP_RD_BYTE);
    c.byte_index = 8'(idx);
    send_cmd(c);
  endtask

  task automatic insert_bits(input int off, input int fw, input logic [63:0] val, input int vw);
    buf_cmd_t c;
    c              = noise_cmd(OP_INSERT);
    c.dst_offset   = OFFSET_BITS'(off);
    c.dst_width    = FWIDTH_BITS'(fw);
    c.field_value  = val;
    c.value_width  = FWIDTH_BITS'(vw);
    send_cmd(c);
  endtask

  // Lets every pending beat come back and the block go quiet.
  task automatic wait_drained();
    int guard;
    idle_cycles(1);
    guard = 0;
    while (pending_reads.size() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Writes bytes_in_use over the register port and reads it back.
  task automatic program_bytes_in_use(input int value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BYTES_IN_USE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_limit = value & 32'h1ff;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(shadow_limit)) begin
      report_mismatch($sformatf("bytes_in_use reads %0h, wrote %0h", prdata, shadow_limit));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Checks every result beat against the oldest expected byte.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && read_valid_o) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected read beat %02h", read_data_o));
      end else begin
        want = pending_reads.pop_front();
        if (read_data_o !== want) begin
          report_mismatch($sformatf("read_data %02h, expected %02h", read_data_o, want));
        end
      end
    end
  end

  // Register value after reset, read without writing it first.
  task automatic test_reset_register();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BYTES_IN_USE_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(BYTES_IN_USE_RST)) begin
      report_mismatch($sformatf("bytes_in_use after reset is %0h", prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Byte writes and reads at both ends of the store, and the unused op.
  task automatic test_byte_access();
    write_byte(0, 8'h00);
    write_byte(BUFFER_BYTES_DEF - 1, 8'hff);
    read_byte(0);
    read_byte(BUFFER_BYTES_DEF - 1);
    send_cmd(noise_cmd(OP_UNUSED));
  endtask

  // Field inserts: full width, narrow fields, zero widths, saturation and the top edge.
  task automatic test_field_insert();
    insert_bits(8, 64, 64'h0123_4567_89ab_cdef, 64);
    read_byte(1);
    read_byte(8);
    // Unaligned 64-bit field spanning nine bytes; byte 9 is left partly unknown.
    insert_bits(12, 64, 64'hfedc_ba98_7654_3210, 64);
    read_byte(2);
    // Only the top dst_width bits of the value_width-bit source are used.
    insert_bits(13, 7, 64'hffff_ffff_ffff_f5a3, 12);
    read_byte(1);
    read_byte(2);
    insert_bits(8, 0, 64'hffff_ffff_ffff_ffff, 64);
    insert_bits(8, 64, 64'hffff_ffff_ffff_ffff, 0);
    read_byte(1);
    // Oversized widths near the end of the store; most bits fall off the end.
    insert_bits(2043, 127, 64'h0, 127);
    insert_bits(2047, 64, 64'hffff_ffff_ffff_ffff, 64);
    read_byte(BUFFER_BYTES_DEF - 1);
  endtask

  // Bytes in use of one, of zero and above the store size.
  task automatic test_limits();
    program_bytes_in_use(1);
    write_byte(1, 8'h5a);
    read_byte(1);
    insert_bits(4, 8, 64'hff, 8);
    read_byte(0);
    program_bytes_in_use(0);
    write_byte(0, 8'h33);
    read_byte(0);
    program_bytes_in_use(511);
    read_byte(0);
    read_byte(1);
  endtask

  function automatic int random_width();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 64);
    if (r < 85) return 0;
    return $urandom_range(127);
  endfunction

  // Random command aimed mostly at the bytes in use.
  function automatic buf_cmd_t random_cmd();
    buf_cmd_t c;
    int       lim;
    int       r;
    int       top;
    lim = active_bytes();
    c   = noise_cmd(OP_WR_BYTE);
    r   = $urandom_range(99);
    c.op = (r < 30) ? OP_WR_BYTE : (r < 62) ? OP_RD_BYTE : (r < 95) ? OP_INSERT : OP_UNUSED;
    if ($urandom_range(9) != 0) begin
      top          = (lim + 1 > 255) ? 255 : lim + 1;
      c.byte_index = 8'($urandom_range(top));
      top          = (lim * 8 + 8 > 2047) ? 2047 : lim * 8 + 8;
      c.dst_offset = OFFSET_BITS'($urandom_range(top));
    end
    c.dst_width   = FWIDTH_BITS'(random_width());
    c.value_width = FWIDTH_BITS'(random_width());
    return c;
  endfunction

  // Random phases with different limits and sender gaps.
  task automatic test_random_traffic();
    int phase_limits [8];
    int gap_pct [4];
    phase_limits = '{256, 1, 511, 40, 256, 2, 300, 0};
    phase_limits[7] = $urandom_range(256, 1);
    gap_pct = '{0, 51, 0, 24};
    for (int p = 0; p < 8; p++) begin
      program_bytes_in_use(phase_limits[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_cmd(random_cmd());
        if ($urandom_range(99) < gap_pct[p % 4]) idle_cycles($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    err_count      = 0;
    shadow_limit   = BYTES_IN_USE_RST;
    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OP_WR_BYTE;
    byte_index_i   = '0;
    byte_data_i    = '0;
    dst_offset_i   = '0;
    dst_width_i    = '0;
    field_value_i  = '0;
    value_width_i  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    for (int i = 0; i < BUFFER_BYTES_DEF; i++) begin
      shadow_bytes[i] = 8'h00;
      bits_written[i] = 8'h00;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_register();
    test_byte_access();
    test_field_insert();
    test_limits();
    test_random_traffic();

    wait_drained();
    if (pending_reads.size() != 0) begin
      report_mismatch($sformatf("%0d read beats never arrived", pending_reads.size()));
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> bit_field_buffer_insert_top.f
rtl/core/bfbi_pkg.sv
rtl/core/bfbi_mem.sv
rtl/core/bfbi_seq.sv
rtl/core/bit_field_buffer_insert_top.sv
dv/tb_bit_field_buffer_insert_top.sv
